// ===== rtl/core/bfha_pkg.sv =====
`timescale 1ns / 1ps
package bfha_pkg;
   localparam int WORD_BYTES    = 4;
   localparam int HEAP_WORDS    = 1024;
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int LOC_W   = $clog2(HEAP_WORDS);
   localparam int WRD_W   = $clog2(HEAP_WORDS + 1);
   localparam int BYTES_W = 13;
   localparam int WB_SH   = $clog2(WORD_BYTES);

   typedef enum logic [2:0] {
      ST_ALLOCATED = 3'd0,
      ST_FULL      = 3'd1,
      ST_IN_USE    = 3'd2,
      ST_FREED     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [LOC_W-1:0] start;
      logic [WRD_W-1:0] words;
   } region_type;

   typedef struct packed {
      logic [7:0]       handle;
      logic [LOC_W-1:0] start;
      logic [WRD_W-1:0] words;
   } alloc_type;
endpackage

// ===== rtl/core/bfha_free_mem.sv =====
`timescale 1ns / 1ps
module bfha_free_mem (
   input  logic                       clock,
   input  logic [bfha_pkg::IDX_W-1:0] rd_addr,
   output bfha_pkg::region_type       rd_data,
   input  logic                       wr_en,
   input  logic [bfha_pkg::IDX_W-1:0] wr_addr,
   input  bfha_pkg::region_type       wr_data
);
   import bfha_pkg::*;
   region_type mem [TABLE_ENTRIES];
   region_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/bfha_alloc_mem.sv =====
`timescale 1ns / 1ps
module bfha_alloc_mem (
   input  logic                       clock,
   input  logic [bfha_pkg::IDX_W-1:0] rd_addr,
   output bfha_pkg::alloc_type        rd_data,
   input  logic                       wr_en,
   input  logic [bfha_pkg::IDX_W-1:0] wr_addr,
   input  bfha_pkg::alloc_type        wr_data
);
   import bfha_pkg::*;
   alloc_type mem [TABLE_ENTRIES];
   alloc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/best_fit_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake       | Words
// req     | in        | req_valid/stall | cmd, handle_id, size_bytes
// rsp     | out       | rsp_valid/stall | status, word_location, block_words
// One request at a time: a pass over each table, paced by the registered read port of its
// memory, a write-back state S_WB1 (and S_WB2 when a free merges on both sides), the result
// state S_RESP, then S_IDLE before the next request is accepted.
// A duplicate allocate or an unknown free skips the free pass and the write-back.
// Reset clears the valid bits at once and seeds free entry 0 with the whole heap.
// The result waits in an output register; req_stall is high until it is taken.
module best_fit_heap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [7:0]                    req_handle_id,
   input  logic [bfha_pkg::BYTES_W-1:0]  req_size_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [bfha_pkg::LOC_W-1:0]    rsp_word_location,
   output logic [bfha_pkg::WRD_W-1:0]    rsp_block_words
);
   import bfha_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ASCAN, S_FSCAN, S_WB1, S_WB2, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [TABLE_ENTRIES-1:0] fvalid_ff, fvalid_in, avalid_ff, avalid_in;
   logic [IDX_W:0]   cnt_ff, cnt_in;       // issue counter, one past depth
   logic             rvld_ff, rvld_in;     // read data of last issue valid
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic             cmd_ff, cmd_in;
   logic [7:0]       hnd_ff, hnd_in;
   logic [WRD_W:0]   need_ff, need_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] aidx_ff, aidx_in;
   region_type       blk_ff, blk_in;       // live block (free) or best region
   logic             best_ff, best_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   logic             pred_ff, pred_in, succ_ff, succ_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in, sidx_ff, sidx_in;
   region_type       preg_ff, preg_in;
   logic [WRD_W-1:0] swords_ff, swords_in;
   logic [2:0]       st_ff, st_in;
   logic [LOC_W-1:0] loc_ff, loc_in;
   logic [WRD_W-1:0] bw_ff, bw_in;
   logic             seed_ff, seed_in;

   logic [IDX_W-1:0] f_raddr, f_waddr, a_waddr;
   region_type       f_rdata, f_wdata;
   alloc_type        a_rdata, a_wdata;
   logic             f_we, a_we;

   bfha_free_mem u_free (.clock, .rd_addr(f_raddr), .rd_data(f_rdata),
      .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata));
   bfha_alloc_mem u_alloc (.clock, .rd_addr(f_raddr), .rd_data(a_rdata),
      .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata));

   logic             aslot_ok, fslot_ok;
   logic [IDX_W-1:0] aslot, fslot;
   always_comb begin
      aslot_ok = 1'b0; aslot = '0; fslot_ok = 1'b0; fslot = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!avalid_ff[i]) begin aslot_ok = 1'b1; aslot = IDX_W'(i); end
         if (!fvalid_ff[i]) begin fslot_ok = 1'b1; fslot = IDX_W'(i); end
      end
   end

   logic [WRD_W:0]   wsum;
   logic [LOC_W+1:0] fend, bend;
   region_type       frd;
   always_comb begin
      state_in = state_ff; fvalid_in = fvalid_ff; avalid_in = avalid_ff;
      cnt_in = cnt_ff; rvld_in = 1'b0; ridx_in = cnt_ff[IDX_W-1:0];
      cmd_in = cmd_ff; hnd_in = hnd_ff; need_in = need_ff;
      hit_in = hit_ff; aidx_in = aidx_ff; blk_in = blk_ff;
      best_in = best_ff; bidx_in = bidx_ff; pred_in = pred_ff; succ_in = succ_ff;
      pidx_in = pidx_ff; sidx_in = sidx_ff; preg_in = preg_ff; swords_in = swords_ff;
      st_in = st_ff; loc_in = loc_ff; bw_in = bw_ff;
      seed_in = seed_ff;
      f_raddr = cnt_ff[IDX_W-1:0];
      f_we = 1'b0; f_waddr = '0; f_wdata = '0;
      a_we = 1'b0; a_waddr = aslot;
      a_wdata = '{handle: hnd_ff, start: blk_ff.start, words: need_ff[WRD_W-1:0]};
      // free entry 0 reads as the whole heap after reset until rewritten
      if (!fvalid_ff[ridx_ff]) begin
         frd = region_type'('0);
      end else if (seed_ff && ridx_ff == '0) begin
         frd = '{start: '0, words: WRD_W'(HEAP_WORDS)};
      end else begin
         frd = f_rdata;
      end
      fend = (LOC_W+2)'(frd.start) + (LOC_W+2)'(frd.words);
      bend = (LOC_W+2)'(blk_ff.start) + (LOC_W+2)'(blk_ff.words);
      wsum = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd; hnd_in = req_handle_id;
               need_in = (WRD_W+1)'((req_size_bytes >> WB_SH)
                  + BYTES_W'((req_size_bytes & BYTES_W'(WORD_BYTES - 1)) != '0));
               hit_in = 1'b0; best_in = 1'b0; pred_in = 1'b0; succ_in = 1'b0;
               cnt_in = '0; state_in = S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (cnt_ff != (IDX_W+1)'(TABLE_ENTRIES)) begin
               cnt_in = cnt_ff + 1'b1; rvld_in = 1'b1;
            end
            // lowest matching index wins; handles are unique anyway
            if (rvld_ff && avalid_ff[ridx_ff] && a_rdata.handle == hnd_ff && !hit_ff) begin
               hit_in = 1'b1; aidx_in = ridx_ff;
               blk_in = '{start: a_rdata.start, words: a_rdata.words};
            end
            if (cnt_ff == (IDX_W+1)'(TABLE_ENTRIES) && !rvld_ff) begin
               cnt_in = '0;
               if (cmd_ff == CMD_ALLOC && hit_in) begin
                  st_in = ST_IN_USE; loc_in = '0; bw_in = '0; state_in = S_RESP;
               end else if (cmd_ff == CMD_FREE && !hit_in) begin
                  st_in = ST_NOT_FOUND; loc_in = '0; bw_in = '0; state_in = S_RESP;
               end else begin
                  state_in = S_FSCAN;
               end
            end
         end
         S_FSCAN: begin
            if (cnt_ff != (IDX_W+1)'(TABLE_ENTRIES)) begin
               cnt_in = cnt_ff + 1'b1; rvld_in = 1'b1;
            end
            if (rvld_ff && fvalid_ff[ridx_ff]) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if ((WRD_W+1)'(frd.words) >= need_ff && (!best_ff
                      || frd.words < blk_ff.words
                      || (frd.words == blk_ff.words && frd.start < blk_ff.start))) begin
                     best_in = 1'b1; bidx_in = ridx_ff; blk_in = frd;
                  end
               end else if (fend == (LOC_W+2)'(blk_ff.start)) begin
                  pred_in = 1'b1; pidx_in = ridx_ff; preg_in = frd;
               end else if ((LOC_W+2)'(frd.start) == bend) begin
                  succ_in = 1'b1; sidx_in = ridx_ff; swords_in = frd.words;
               end
            end
            if (cnt_ff == (IDX_W+1)'(TABLE_ENTRIES) && !rvld_ff) begin
               state_in = S_WB1;
            end
         end
         S_WB1: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_ALLOC) begin
               if (need_ff == '0 || !best_ff || !aslot_ok) begin
                  st_in = ST_FULL; loc_in = '0; bw_in = '0;
               end else begin
                  a_we = 1'b1; avalid_in[aslot] = 1'b1;
                  st_in = ST_ALLOCATED; loc_in = blk_ff.start;
                  bw_in = need_ff[WRD_W-1:0];
                  f_we = 1'b1; f_waddr = bidx_ff;
                  if ((WRD_W+1)'(blk_ff.words) == need_ff) begin
                     fvalid_in[bidx_ff] = 1'b0;
                  end else begin
                     f_wdata.start = blk_ff.start + LOC_W'(need_ff);
                     f_wdata.words = blk_ff.words - need_ff[WRD_W-1:0];
                  end
               end
            end else begin
               avalid_in[aidx_ff] = 1'b0;
               st_in = ST_FREED; loc_in = blk_ff.start; bw_in = blk_ff.words;
               f_we = 1'b1;
               if (pred_ff) begin
                  f_waddr = pidx_ff;
                  wsum = (WRD_W+1)'(preg_ff.words) + (WRD_W+1)'(blk_ff.words)
                     + (succ_ff ? (WRD_W+1)'(swords_ff) : '0);
                  f_wdata = '{start: preg_ff.start, words: wsum[WRD_W-1:0]};
                  if (succ_ff) state_in = S_WB2;
               end else if (succ_ff) begin
                  f_waddr = sidx_ff;
                  wsum = (WRD_W+1)'(swords_ff) + (WRD_W+1)'(blk_ff.words);
                  f_wdata = '{start: blk_ff.start, words: wsum[WRD_W-1:0]};
               end else if (fslot_ok) begin
                  f_waddr = fslot; f_wdata = blk_ff; fvalid_in[fslot] = 1'b1;
               end else begin
                  f_we = 1'b0;  // drop words, no room
               end
            end
         end
         S_WB2: begin
            fvalid_in[sidx_ff] = 1'b0; state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // drop the seed once entry 0 is written
      if (f_we && f_waddr == '0) seed_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fvalid_ff <= TABLE_ENTRIES'(1);
         avalid_ff <= '0;
         rvld_ff <= 1'b0;
         cnt_ff <= '0;
         seed_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         fvalid_ff <= fvalid_in;
         avalid_ff <= avalid_in;
         rvld_ff <= rvld_in;
         cnt_ff <= cnt_in;
         seed_ff <= seed_in;
      end
      ridx_ff <= ridx_in; cmd_ff <= cmd_in; hnd_ff <= hnd_in; need_ff <= need_in;
      hit_ff <= hit_in; aidx_ff <= aidx_in;
      if (reset) blk_ff <= '0; else blk_ff <= blk_in;
      best_ff <= best_in; bidx_ff <= bidx_in; pred_ff <= pred_in; succ_ff <= succ_in;
      pidx_ff <= pidx_in; sidx_ff <= sidx_in; preg_ff <= preg_in; swords_ff <= swords_in;
      st_ff <= st_in; loc_ff <= loc_in; bw_ff <= bw_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_word_location = loc_ff;
   assign rsp_block_words = bw_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB1 && cmd_ff == CMD_ALLOC && st_in == ST_ALLOCATED)
         |=> $countones(avalid_ff) == $countones($past(avalid_ff)) + 1)
      else $error("allocate did not take one slot");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while held");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB1 && cmd_ff == CMD_FREE) |=> !avalid_ff[$past(aidx_ff)])
      else $error("freed handle still live");
endmodule
